// ===== design/cpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the closest point on triangle block.
// No dependencies.
package cpt_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DIST_WIDTH      = 64;
  localparam int REGION_WIDTH    = 3;

  localparam logic [REGION_WIDTH-1:0] RGN_VERT_A   = 3'd0;
  localparam logic [REGION_WIDTH-1:0] RGN_VERT_B   = 3'd1;
  localparam logic [REGION_WIDTH-1:0] RGN_EDGE_AB  = 3'd2;
  localparam logic [REGION_WIDTH-1:0] RGN_VERT_C   = 3'd3;
  localparam logic [REGION_WIDTH-1:0] RGN_EDGE_AC  = 3'd4;
  localparam logic [REGION_WIDTH-1:0] RGN_EDGE_BC  = 3'd5;
  localparam logic [REGION_WIDTH-1:0] RGN_INTERIOR = 3'd6;

endpackage

// ===== design/cpt_delay.sv =====
`timescale 1ns / 1ps
// Enabled shift line that carries side data alongside the main pipeline.
// No dependencies.
module cpt_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int j = 1; j < DEPTH; j++) begin
        sr[j] <= sr[j-1];
      end
    end
  end

  assign dout = sr[DEPTH-1];

endmodule

// ===== design/cpt_wmul.sv =====
`timescale 1ns / 1ps
// Two-stage signed multiplier: four half-width partial products, then their sum.
// No dependencies.
module cpt_wmul #(
  parameter int AW = 68
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] op_a,
  input  logic signed [AW-1:0] op_b,
  output logic signed [2*AW-1:0] prod
);

  localparam int L = AW / 2;
  localparam int H = AW - L;
  localparam int PW = 2 * AW;

  logic signed [H-1:0]     a_hi, b_hi;
  logic signed [L:0]       a_lo, b_lo;
  logic signed [2*H-1:0]   pp_hh;
  logic signed [H+L:0]     pp_hl, pp_lh;
  logic        [2*L-1:0]   pp_ll;
  logic signed [PW-1:0]    hh_x, hl_x, lh_x, ll_x;

  assign a_hi = op_a[AW-1:L];
  assign b_hi = op_b[AW-1:L];
  assign a_lo = $signed({1'b0, op_a[L-1:0]});
  assign b_lo = $signed({1'b0, op_b[L-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a_hi * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_ll <= op_a[L-1:0] * op_b[L-1:0];
    end
  end

  assign hh_x = {{(PW-2*H){pp_hh[2*H-1]}}, pp_hh};
  assign hl_x = {{(PW-H-L-1){pp_hl[H+L]}}, pp_hl};
  assign lh_x = {{(PW-H-L-1){pp_lh[H+L]}}, pp_lh};
  assign ll_x = $signed({{(PW-2*L){1'b0}}, pp_ll});

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (hh_x <<< (2*L)) + (hl_x <<< L) + (lh_x <<< L) + ll_x;
    end
  end

endmodule

// ===== design/cpt_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, result clamped to [0, 1.0].
// No dependencies.
module cpt_div #(
  parameter int NW = 140,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic [F:0]           quo
);

  logic [NW-1:0] rem [F+1];
  logic [NW-1:0] dvs [F+1];
  logic [F-1:0]  qt  [F+1];
  logic          zr  [F+1];
  logic          on  [F+1];
  logic          zero_in;

  // zero when divisor not positive or numerator negative
  assign zero_in = den[NW-1] || (den == '0) || num[NW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      zr[0]  <= zero_in;
      on[0]  <= !zero_in && (den <= num);
      rem[0] <= num;
      dvs[0] <= den;
      qt[0]  <= '0;
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_step
    logic [NW:0] sh, df;
    logic        ge;
    assign sh = {rem[k-1], 1'b0};
    assign df = sh - {1'b0, dvs[k-1]};
    assign ge = sh >= {1'b0, dvs[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        zr[k]  <= zr[k-1];
        on[k]  <= on[k-1];
        dvs[k] <= dvs[k-1];
        rem[k] <= ge ? df[NW-1:0] : sh[NW-1:0];
        qt[k]  <= {qt[k-1][F-2:0], ge};
      end
    end
  end

  assign quo = zr[F] ? '0 : (on[F] ? {1'b1, {F{1'b0}}} : {1'b0, qt[F]});

endmodule

// ===== design/closest_point_on_triangle.sv =====
`timescale 1ns / 1ps
// Closest point on a 3-D triangle, fully pipelined.
// One transfer accepted every cycle unless in_stall is high (out_valid with out_stall).
// The divider lanes have an operand stage, then one quotient bit per stage.
// Reset (rst, synchronous) clears the valid bits only; data registers are not reset.
// Uses cpt_pkg, cpt_delay, cpt_wmul, cpt_div.
module closest_point_on_triangle
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] near_x,
  output logic signed [COORD_WIDTH-1:0] near_y,
  output logic signed [COORD_WIDTH-1:0] near_z,
  output logic [FRAC_BITS:0]            weight_u,
  output logic [FRAC_BITS:0]            weight_v,
  output logic [REGION_WIDTH-1:0]       region,
  output logic [DIST_WIDTH-1:0]         dist_sq,
  output logic                          degenerate
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * W + 4;
  localparam int PW   = 2 * DW;
  localparam int VW   = PW + 1;
  localparam int DENW = VW + 2;
  localparam int NW   = DENW + 1;
  localparam int LAT  = 15 + F;
  localparam int CW   = 4 * W + 3 * (W + 1);
  localparam int GW   = 3 * CW;
  localparam int TW   = W + F + 4;
  localparam int DSW  = 2 * W + 4;
  localparam int EXW  = DSW + DIST_WIDTH;
  localparam int TLW  = 2 * (F + 1) + REGION_WIDTH + 1;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic           en;
  logic [LAT-1:0] vld;

  assign in_stall  = out_valid & out_stall;
  assign en        = ~in_stall;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: edge and point vectors
  logic signed [W-1:0] in_p [3], in_a [3], in_b [3], in_c [3];
  logic signed [W-1:0] p1 [3], a1 [3], b1 [3], c1 [3];
  logic signed [W:0]   edg [2][3];
  logic signed [W:0]   vec [3][3];
  logic signed [W:0]   bc1 [3];
  logic [GW-1:0]       geo_in, geo_out;

  assign in_p = '{point_x, point_y, point_z};
  assign in_a = '{vert_a_x, vert_a_y, vert_a_z};
  assign in_b = '{vert_b_x, vert_b_y, vert_b_z};
  assign in_c = '{vert_c_x, vert_c_y, vert_c_z};

  for (genvar i = 0; i < 3; i++) begin : g_s1
    always_ff @(posedge clk) begin
      if (en) begin
        p1[i]     <= in_p[i];
        a1[i]     <= in_a[i];
        b1[i]     <= in_b[i];
        c1[i]     <= in_c[i];
        edg[0][i] <= (W+1)'(in_b[i]) - (W+1)'(in_a[i]);
        edg[1][i] <= (W+1)'(in_c[i]) - (W+1)'(in_a[i]);
        bc1[i]    <= (W+1)'(in_c[i]) - (W+1)'(in_b[i]);
        vec[0][i] <= (W+1)'(in_p[i]) - (W+1)'(in_a[i]);
        vec[1][i] <= (W+1)'(in_p[i]) - (W+1)'(in_b[i]);
        vec[2][i] <= (W+1)'(in_p[i]) - (W+1)'(in_c[i]);
      end
    end
    assign geo_in[i*CW +: CW] = {p1[i], a1[i], b1[i], c1[i], edg[0][i], edg[1][i], bc1[i]};
  end

  cpt_delay #(.WIDTH(GW), .DEPTH(8 + F)) u_geo (
    .clk(clk), .en(en), .din(geo_in), .dout(geo_out)
  );

  // stages 2 and 3: six dot products d1..d6
  logic signed [2*W+1:0] prd [6][3];
  logic signed [DW-1:0]  dt [6];

  for (genvar k = 0; k < 6; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      always_ff @(posedge clk) begin
        if (en) begin
          prd[k][i] <= edg[k%2][i] * vec[k/2][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dt[k] <= DW'(prd[k][0]) + DW'(prd[k][1]) + DW'(prd[k][2]);
      end
    end
  end

  // stages 4 and 5: cross terms of the barycentric numerators
  logic signed [DW-1:0] ma [6], mb [6];
  logic signed [PW-1:0] wp [6];

  assign ma = '{dt[0], dt[2], dt[4], dt[0], dt[2], dt[4]};
  assign mb = '{dt[3], dt[1], dt[1], dt[5], dt[5], dt[3]};

  for (genvar k = 0; k < 6; k++) begin : g_wm
    cpt_wmul #(.AW(DW)) u_mul (
      .clk(clk), .en(en), .op_a(ma[k]), .op_b(mb[k]), .prod(wp[k])
    );
  end

  logic [6*DW-1:0]      dpk_in, dpk_out;
  logic signed [DW-1:0] dd [6];

  for (genvar k = 0; k < 6; k++) begin : g_dpk
    assign dpk_in[k*DW +: DW] = dt[k];
    assign dd[k] = dpk_out[k*DW +: DW];
  end

  cpt_delay #(.WIDTH(6*DW), .DEPTH(3)) u_dly_d (
    .clk(clk), .en(en), .din(dpk_in), .dout(dpk_out)
  );

  // stage 6: va, vb, vc
  logic signed [VW-1:0] va6, vb6, vc6;

  always_ff @(posedge clk) begin
    if (en) begin
      va6 <= VW'(wp[4]) - VW'(wp[5]);
      vb6 <= VW'(wp[2]) - VW'(wp[3]);
      vc6 <= VW'(wp[0]) - VW'(wp[1]);
    end
  end

  // stage 7: region choice, interior denominator
  logic signed [DW:0]     e13, e26, e43, e56;
  logic signed [DW:0]     e43_n, e56_n;
  logic signed [DENW-1:0] den_n, den7;
  logic signed [VW-1:0]   vb7, vc7;
  logic signed [DW-1:0]   d1_7, d2_7;
  logic [REGION_WIDTH-1:0] rg_n, rg7;
  logic                    dg7;

  assign e43_n = (DW+1)'(dd[3]) - (DW+1)'(dd[2]);
  assign e56_n = (DW+1)'(dd[4]) - (DW+1)'(dd[5]);
  assign den_n = DENW'(va6) + DENW'(vb6) + DENW'(vc6);

  always_comb begin
    if (dd[0] <= 0 && dd[1] <= 0) begin
      rg_n = RGN_VERT_A;
    end else if (dd[2] >= 0 && dd[3] <= dd[2]) begin
      rg_n = RGN_VERT_B;
    end else if (vc6 <= 0 && dd[0] >= 0 && dd[2] <= 0) begin
      rg_n = RGN_EDGE_AB;
    end else if (dd[5] >= 0 && dd[4] <= dd[5]) begin
      rg_n = RGN_VERT_C;
    end else if (vb6 <= 0 && dd[1] >= 0 && dd[5] <= 0) begin
      rg_n = RGN_EDGE_AC;
    end else if (va6 <= 0 && e43_n >= 0 && e56_n >= 0) begin
      rg_n = RGN_EDGE_BC;
    end else begin
      rg_n = RGN_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rg7  <= rg_n;
      dg7  <= (rg_n == RGN_INTERIOR) && (den_n == '0);
      den7 <= den_n;
      vb7  <= vb6;
      vc7  <= vc6;
      d1_7 <= dd[0];
      d2_7 <= dd[1];
      e13  <= (DW+1)'(dd[0]) - (DW+1)'(dd[2]);
      e26  <= (DW+1)'(dd[1]) - (DW+1)'(dd[5]);
      e43  <= e43_n;
      e56  <= e56_n;
    end
  end

  // stage 8: divider operands; a negative denominator moves its sign onto the numerators
  logic signed [NW-1:0] nu_n, du_n, nv_n, dv_n, nu8, du8, nv8, dv8;
  logic signed [NW-1:0] vb_x, vc_x, den_x;
  logic [REGION_WIDTH-1:0] rg8;
  logic                    dg8, dneg;

  assign vb_x  = NW'(vb7);
  assign vc_x  = NW'(vc7);
  assign den_x = NW'(den7);
  assign dneg  = den7[DENW-1];

  always_comb begin
    nu_n = '0;
    du_n = '0;
    nv_n = '0;
    dv_n = '0;
    case (rg7)
      RGN_EDGE_AB: begin
        nu_n = NW'(d1_7);
        du_n = NW'(e13);
      end
      RGN_EDGE_AC: begin
        nv_n = NW'(d2_7);
        dv_n = NW'(e26);
      end
      RGN_EDGE_BC: begin
        nv_n = NW'(e43);
        dv_n = NW'(e43) + NW'(e56);
      end
      RGN_INTERIOR: begin
        nu_n = dneg ? -vb_x : vb_x;
        nv_n = dneg ? -vc_x : vc_x;
        du_n = dneg ? -den_x : den_x;
        dv_n = du_n;
      end
      default: begin
        nu_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nu8 <= nu_n;
      du8 <= du_n;
      nv8 <= nv_n;
      dv8 <= dv_n;
      rg8 <= rg7;
      dg8 <= dg7;
    end
  end

  // stages 9 .. 9+F: divider lanes
  logic [F:0] qu, qv;

  cpt_div #(.NW(NW), .F(F)) u_div_u (
    .clk(clk), .en(en), .num(nu8), .den(du8), .quo(qu)
  );

  cpt_div #(.NW(NW), .F(F)) u_div_v (
    .clk(clk), .en(en), .num(nv8), .den(dv8), .quo(qv)
  );

  logic [REGION_WIDTH:0]   rd_out;
  logic [REGION_WIDTH-1:0] rg_d;
  logic                    dg_d;

  cpt_delay #(.WIDTH(REGION_WIDTH + 1), .DEPTH(F + 1)) u_dly_rg (
    .clk(clk), .en(en), .din({rg8, dg8}), .dout(rd_out)
  );

  assign rg_d = rd_out[REGION_WIDTH:1];
  assign dg_d = rd_out[0];

  // geometry at the divider output
  logic signed [W-1:0] gp [3], ga [3], gb [3], gc [3];
  logic signed [W:0]   gab [3], gac [3], gbc [3];

  for (genvar i = 0; i < 3; i++) begin : g_unpk
    assign {gp[i], ga[i], gb[i], gc[i], gab[i], gac[i], gbc[i]} = geo_out[i*CW +: CW];
  end

  // P1: weights and blend operands
  logic [F:0]          u_n, v_n, s1_n, s2_n, s1, s2;
  logic [F+1:0]        uv_sum;
  logic [1:0]          bsel_n;
  logic [1:0]          e1sel_n;
  logic                e2on_n;
  logic signed [W-1:0] base [3];
  logic signed [W:0]   e1 [3], e2 [3];

  assign uv_sum = (F+2)'(qu) + (F+2)'(qv);

  // bsel: 0 a, 1 b, 2 c; e1sel: 0 ab, 1 bc
  always_comb begin
    u_n     = '0;
    v_n     = '0;
    s1_n    = '0;
    s2_n    = '0;
    bsel_n  = 2'd0;
    e1sel_n = 2'd0;
    e2on_n  = 1'b0;
    case (rg_d)
      RGN_VERT_A: begin
        bsel_n = 2'd0;
      end
      RGN_VERT_B: begin
        bsel_n = 2'd1;
        u_n    = ONE;
      end
      RGN_EDGE_AB: begin
        u_n  = qu;
        s1_n = qu;
      end
      RGN_VERT_C: begin
        bsel_n = 2'd2;
        v_n    = ONE;
      end
      RGN_EDGE_AC: begin
        v_n    = qv;
        s2_n   = qv;
        e2on_n = 1'b1;
      end
      RGN_EDGE_BC: begin
        bsel_n  = 2'd1;
        e1sel_n = 2'd1;
        v_n     = qv;
        u_n     = ONE - qv;
        s1_n    = qv;
      end
      default: begin
        if (!dg_d) begin
          u_n    = qu;
          v_n    = (uv_sum > (F+2)'(ONE)) ? ONE - qu : qv;
          s1_n   = u_n;
          s2_n   = v_n;
          e2on_n = 1'b1;
        end
      end
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_p1
    always_ff @(posedge clk) begin
      if (en) begin
        case (bsel_n)
          2'd1:    base[i] <= gb[i];
          2'd2:    base[i] <= gc[i];
          default: base[i] <= ga[i];
        endcase
        e1[i] <= (e1sel_n == 2'd1) ? gbc[i] : gab[i];
        e2[i] <= e2on_n ? gac[i] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_n;
      s2 <= s2_n;
    end
  end

  logic [TLW-1:0] tl_out;

  cpt_delay #(.WIDTH(TLW), .DEPTH(6)) u_dly_tail (
    .clk(clk), .en(en), .din({u_n, v_n, rg_d, dg_d}), .dout(tl_out)
  );

  assign {weight_u, weight_v, region, degenerate} = tl_out;

  logic [3*W-1:0] pk_in, pk_out;

  for (genvar i = 0; i < 3; i++) begin : g_ppk
    assign pk_in[i*W +: W] = gp[i];
  end

  cpt_delay #(.WIDTH(3*W), .DEPTH(3)) u_dly_p (
    .clk(clk), .en(en), .din(pk_in), .dout(pk_out)
  );

  // P2 .. P6: blend, distance
  logic signed [W+F+2:0] m1 [3], m2 [3];
  logic signed [W-1:0]   base2 [3], q3 [3], q4 [3], q5 [3];
  logic signed [TW-1:0]  tsum [3];
  logic signed [W:0]     dq [3];
  logic signed [2*W+1:0] sqp [3];
  logic [2*W+1:0]        sq [3];
  logic [DSW-1:0]        dsum;
  logic [EXW-1:0]        dext;

  for (genvar i = 0; i < 3; i++) begin : g_tail
    assign tsum[i] = (TW'(base2[i]) <<< F) + TW'(m1[i]) + TW'(m2[i]);
    assign sqp[i]  = dq[i] * dq[i];
    always_ff @(posedge clk) begin
      if (en) begin
        m1[i]    <= e1[i] * $signed({1'b0, s1});
        m2[i]    <= e2[i] * $signed({1'b0, s2});
        base2[i] <= base[i];
        q3[i]    <= tsum[i][F +: W];
        dq[i]    <= (W+1)'($signed(pk_out[i*W +: W])) - (W+1)'(q3[i]);
        q4[i]    <= q3[i];
        sq[i]    <= sqp[i];
        q5[i]    <= q4[i];
      end
    end
  end

  assign dsum = DSW'(sq[0]) + DSW'(sq[1]) + DSW'(sq[2]);
  assign dext = EXW'(dsum);

  always_ff @(posedge clk) begin
    if (en) begin
      near_x  <= q5[0];
      near_y  <= q5[1];
      near_z  <= q5[2];
      dist_sq <= (|dext[EXW-1:DIST_WIDTH]) ? '1 : dext[DIST_WIDTH-1:0];
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for closest_point_on_triangle: directed region, extreme and degenerate
// queries, then random triangles, checked against a wide-integer predictor.
// Depends on cpt_pkg and the closest_point_on_triangle RTL.
module testbench;
  import cpt_pkg::*;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int LATENCY = 15 + FB;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_QUERIES = 1830;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t vec_t [3];
  typedef logic signed [255:0] big_t;
  typedef big_t bvec_t [3];

  typedef struct {
    coord_t          nx, ny, nz;
    logic [FB:0]     u, v;
    logic [REGION_WIDTH-1:0] rgn;
    logic [DIST_WIDTH-1:0]   dsq;
    logic            degen;
  } nearest_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  coord_t point_x = 0, point_y = 0, point_z = 0;
  coord_t vert_a_x = 0, vert_a_y = 0, vert_a_z = 0;
  coord_t vert_b_x = 0, vert_b_y = 0, vert_b_z = 0;
  coord_t vert_c_x = 0, vert_c_y = 0, vert_c_z = 0;
  coord_t near_x, near_y, near_z;
  logic [FB:0] weight_u, weight_v;
  logic [REGION_WIDTH-1:0] region;
  logic [DIST_WIDTH-1:0] dist_sq;
  logic degenerate;

  nearest_t expected_q[$];
  int errors = 0, sent = 0, checked = 0, cycles = 0;
  int region_hits [8];
  bit out_busy = 0;

  closest_point_on_triangle dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic big_t dot3(bvec_t x, bvec_t y);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // floor(n * 2^FB / d) clamped to [0, 1.0]
  function automatic big_t weight_of(big_t n, big_t d);
    big_t one = big_t'(1) <<< FB;
    if (d <= 0 || n < 0) return 0;
    if (d <= n) return one;
    return (n <<< FB) / d;
  endfunction

  function automatic bvec_t blend(bvec_t base, bvec_t e1, big_t s1, bvec_t e2, big_t s2);
    bvec_t q;
    for (int i = 0; i < 3; i++) q[i] = ((base[i] <<< FB) + e1[i] * s1 + e2[i] * s2) >>> FB;
    return q;
  endfunction

  function automatic nearest_t nearest_point(vec_t p, vec_t a, vec_t b, vec_t c);
    bvec_t pw, aw, bw, ab, ac, bc, ap, bp, cp, q;
    big_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, n, u, v, acc, df;
    big_t one = big_t'(1) <<< FB;
    nearest_t r;
    u = 0; v = 0; r.degen = 0;
    for (int i = 0; i < 3; i++) begin
      pw[i] = p[i]; aw[i] = a[i]; bw[i] = b[i];
      ab[i] = bw[i] - aw[i];
      ac[i] = big_t'(c[i]) - aw[i];
      bc[i] = big_t'(c[i]) - bw[i];
      ap[i] = pw[i] - aw[i];
      bp[i] = pw[i] - bw[i];
      cp[i] = pw[i] - big_t'(c[i]);
    end
    d1 = dot3(ab, ap); d2 = dot3(ac, ap);
    d3 = dot3(ab, bp); d4 = dot3(ac, bp);
    d5 = dot3(ab, cp); d6 = dot3(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    if (d1 <= 0 && d2 <= 0) begin
      r.rgn = RGN_VERT_A; q = aw;
    end else if (d3 >= 0 && d4 <= d3) begin
      r.rgn = RGN_VERT_B; q = bw; u = one;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      r.rgn = RGN_EDGE_AB; u = weight_of(d1, d1 - d3);
      q = blend(aw, ab, u, ac, 0);
    end else if (d6 >= 0 && d5 <= d6) begin
      r.rgn = RGN_VERT_C;
      for (int i = 0; i < 3; i++) q[i] = c[i];
      v = one;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      r.rgn = RGN_EDGE_AC; v = weight_of(d2, d2 - d6);
      q = blend(aw, ab, 0, ac, v);
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      n = d4 - d3;
      r.rgn = RGN_EDGE_BC; v = weight_of(n, n + (d5 - d6));
      u = one - v;
      q = blend(bw, bc, v, ab, 0);
    end else begin
      r.rgn = RGN_INTERIOR;
      den = va + vb + vc;
      if (den == 0) begin
        r.degen = 1; q = aw;
      end else begin
        if (den < 0) begin
          den = -den; vb = -vb; vc = -vc;
        end
        u = weight_of(vb, den);
        v = weight_of(vc, den);
        if (u + v > one) v = one - u;
        q = blend(aw, ab, u, ac, v);
      end
    end
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      df = pw[i] - q[i];
      acc = acc + df * df;
    end
    r.dsq = (acc[255:64] != 0) ? '1 : acc[63:0];
    r.nx = q[0][CW-1:0]; r.ny = q[1][CW-1:0]; r.nz = q[2][CW-1:0];
    r.u = u[FB:0]; r.v = v[FB:0];
    return r;
  endfunction

  // ---------------- stimulus ----------------
  function automatic int pick_gap();
    int k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  bit no_gaps = 0;

  task automatic send_query(vec_t p, vec_t a, vec_t b, vec_t c);
    int gap;
    @(negedge clk);
    in_valid <= 1;
    point_x <= p[0]; point_y <= p[1]; point_z <= p[2];
    vert_a_x <= a[0]; vert_a_y <= a[1]; vert_a_z <= a[2];
    vert_b_x <= b[0]; vert_b_y <= b[1]; vert_b_z <= b[2];
    vert_c_x <= c[0]; vert_c_y <= c[1]; vert_c_z <= c[2];
    do @(posedge clk); while (in_stall);
    expected_q.push_back(nearest_point(p, a, b, c));
    sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic vec_t mk(int x, int y, int z);
    vec_t r;
    r[0] = x <<< FB; r[1] = y <<< FB; r[2] = z <<< FB;
    return r;
  endfunction

  function automatic vec_t fill(coord_t x);
    vec_t r;
    r[0] = x; r[1] = x; r[2] = x;
    return r;
  endfunction

  task automatic test_regions();
    vec_t a = mk(0, 0, 0), b = mk(4, 0, 0), c = mk(0, 4, 0);
    send_query(mk(-1, -1, 1), a, b, c);
    send_query(mk(5, -1, 0), a, b, c);
    send_query(mk(2, -1, 3), a, b, c);
    send_query(mk(-1, 5, 0), a, b, c);
    send_query(mk(-1, 2, -2), a, b, c);
    send_query(mk(3, 3, 1), a, b, c);
    send_query(mk(1, 1, 2), a, b, c);
    send_query(a, a, b, c);
    // odd fractions, clockwise winding
    send_query('{32'sh0001_8001, 32'sh0000_4003, 32'sh0000_0007}, a, c, b);
  endtask

  task automatic test_degenerate();
    vec_t a = mk(0, 0, 0);
    send_query(mk(3, 1, 1), a, mk(4, 0, 0), mk(8, 0, 0));
    send_query(mk(1, 1, 0), a, a, mk(0, 4, 0));
    send_query(mk(1, 1, 0), a, mk(4, 0, 0), a);
    send_query(mk(1, 2, 3), mk(2, 2, 2), mk(2, 2, 2), mk(2, 2, 2));
    send_query(mk(2, 2, 1), mk(0, 4, 0), mk(4, 0, 0), mk(4, 0, 0));
  endtask

  task automatic test_extremes();
    coord_t mx = {1'b0, {(CW-1){1'b1}}}, mn = {1'b1, {(CW-1){1'b0}}};
    send_query(fill(mx), fill(mx), fill(mx), fill(mx));
    send_query(fill(mn), fill(mn), fill(mn), fill(mn));
    send_query(fill(mx), fill(mn), fill(mx), fill(mn));
    send_query(fill(mn), fill(mx), fill(mn), fill(mx));
    send_query(fill(mx), fill(mn), '{mx, mn, mn}, '{mn, mx, mn});
    send_query('{mn, mx, 0}, '{mx, mx, mn}, '{mn, mn, mx}, '{0, mx, mx});
    send_query(fill(-1), fill(0), '{mx, 0, 0}, '{0, mn, 0});
  endtask

  function automatic vec_t jitter(vec_t base, int span);
    vec_t r;
    for (int i = 0; i < 3; i++) r[i] = base[i] + $signed($urandom_range(0, 2 * span)) - span;
    return r;
  endfunction

  task automatic test_random();
    vec_t ctr, p, a, b, c;
    int span, kind;
    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      if (n % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_QUERIES / 2) wait_drained();
      kind = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) ctr[i] = $urandom;
      if (kind < 10) begin
        for (int i = 0; i < 3; i++) begin
          p[i] = $urandom; a[i] = $urandom; b[i] = $urandom; c[i] = $urandom;
        end
      end else begin
        span = 1 << $urandom_range(4, 26);
        a = jitter(ctr, span); b = jitter(ctr, span); c = jitter(ctr, span);
        p = jitter(ctr, 2 * span);
        if (kind < 18) c = (kind < 14) ? b : a;
        else if (kind < 24) begin
          // a, b, c on a line
          for (int i = 0; i < 3; i++) c[i] = b[i] + (b[i] - a[i]);
        end else if (kind < 28) begin
          for (int i = 0; i < 3; i++) p[i] = p[i] >>> 8;
          for (int i = 0; i < 3; i++) a[i] = a[i] >>> 8;
          b = jitter(a, 64); c = jitter(a, 64);
        end
      end
      send_query(p, a, b, c);
    end
    no_gaps = 0;
  endtask

  // ---------------- result side ----------------
  always @(negedge clk) begin
    int k;
    if (!rst) begin
      if (out_busy) begin
        out_stall <= ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 299) == 0) out_busy <= 0;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 2) out_stall <= 1;
        else if (k < 3) out_busy <= 1;
        else out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    nearest_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer on the result side", $time);
        errors++;
      end else begin
        e = expected_q.pop_front();
        checked++;
        region_hits[e.rgn + (e.degen ? 1 : 0) * 1]++;
        if ({near_x, near_y, near_z} !== {e.nx, e.ny, e.nz})
          $display("%0t: near exp %h %h %h got %h %h %h", $time,
                   e.nx, e.ny, e.nz, near_x, near_y, near_z);
        if (weight_u !== e.u) $display("%0t: weight_u exp %h got %h", $time, e.u, weight_u);
        if (weight_v !== e.v) $display("%0t: weight_v exp %h got %h", $time, e.v, weight_v);
        if (region !== e.rgn) $display("%0t: region exp %0d got %0d", $time, e.rgn, region);
        if (dist_sq !== e.dsq) $display("%0t: dist_sq exp %h got %h", $time, e.dsq, dist_sq);
        if (degenerate !== e.degen)
          $display("%0t: degenerate exp %b got %b", $time, e.degen, degenerate);
        if ({near_x, near_y, near_z, weight_u, weight_v, region, dist_sq, degenerate} !==
            {e.nx, e.ny, e.nz, e.u, e.v, e.rgn, e.dsq, e.degen})
          errors++;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_regions();
    test_degenerate();
    test_extremes();
    wait_drained();
    test_random();
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    $display("%0d queries sent, %0d results checked; region counts a %0d b %0d ab %0d c %0d",
             sent, checked, region_hits[0], region_hits[1], region_hits[2], region_hits[3]);
    $display("ac %0d bc %0d interior %0d degenerate %0d", region_hits[4], region_hits[5],
             region_hits[6], region_hits[7]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
